FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated off while reset is asserted.
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, gated off while reset is asserted.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/core/tsmx_pkg.sv
`timescale 1ns / 1ps

package tsmx_pkg;

    // Input function codes
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_FADE  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_ANODE_ON    = 2'd0;
    localparam logic [1:0] CFG_CATHODE_OFF = 2'd1;
    localparam logic [1:0] CFG_BLANK       = 2'd2;

    // Reset values of the tick registers
    localparam logic [7:0] ANODE_ON_RST    = 8'd40;
    localparam logic [7:0] CATHODE_OFF_RST = 8'd8;
    localparam logic [7:0] BLANK_RST       = 8'd4;

    // Scan phase codes
    localparam logic [2:0] PH_SELECT = 3'd0;
    localparam logic [2:0] PH_ENABLE = 3'd1;
    localparam logic [2:0] PH_HOLD   = 3'd2;
    localparam logic [2:0] PH_COFF   = 3'd3;
    localparam logic [2:0] PH_BLANK  = 3'd4;

    typedef struct packed {
        logic [3:0] new_digit;
        logic [3:0] old_digit;
    } digit_pair_t;

    typedef struct packed {
        logic        en;
        logic [2:0]  addr;
        digit_pair_t data;
    } store_wr_t;

    typedef struct packed {
        logic       anode_on;
        logic [2:0] anode_index;
        logic       cathode_on;
        logic [3:0] cathode_digit;
    } result_t;

endpackage

FILE: rtl/core/tsmx_digit_store.sv
`timescale 1ns / 1ps

// Digit pair memory, one entry per position. Registered read; a write to the
// address being read in the same cycle is forwarded.
module tsmx_digit_store #(
    parameter int DIGITS = 6
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tsmx_pkg::store_wr_t   wr,
    input  logic [2:0]            rd_addr,
    output tsmx_pkg::digit_pair_t rd_data
);

    localparam int AW = (DIGITS > 1) ? $clog2(DIGITS) : 1;

    tsmx_pkg::digit_pair_t mem [DIGITS];
    tsmx_pkg::digit_pair_t rd_q_reg;
    tsmx_pkg::digit_pair_t fwd_reg;
    logic [DIGITS-1:0]     valid_reg;
    logic                  rd_vld_reg;
    logic                  hit_reg;

    // Payload: memory array, read data and forwarded data
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr[AW-1:0]] <= wr.data;
        end
        rd_q_reg <= mem[rd_addr[AW-1:0]];
        fwd_reg  <= wr.data;
    end

    // Valid bits stand in for the all-zero reset of the array
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
            hit_reg    <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr[AW-1:0]] <= 1'b1;
            end
            rd_vld_reg <= valid_reg[rd_addr[AW-1:0]];
            hit_reg    <= wr.en && (wr.addr == rd_addr);
        end
    end

    always_comb
    begin
        if (hit_reg)
        begin
            rd_data = fwd_reg;
        end
        else if (rd_vld_reg)
        begin
            rd_data = rd_q_reg;
        end
        else
        begin
            rd_data = '0;
        end
    end

endmodule

FILE: rtl/core/tsmx_out_buf.sv
`timescale 1ns / 1ps

// Two-entry output buffer: head register plus skid register.
module tsmx_out_buf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  tsmx_pkg::result_t   push_data,
    output logic                full,
    output logic                out_valid,
    input  logic                out_stall,
    output tsmx_pkg::result_t   out_data
);

    tsmx_pkg::result_t head_reg;
    tsmx_pkg::result_t skid_reg;
    logic              head_vld_reg;
    logic              skid_vld_reg;
    logic              pop;

    assign pop       = head_vld_reg && !out_stall;
    assign full      = skid_vld_reg;
    assign out_valid = head_vld_reg;
    assign out_data  = head_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_vld_reg <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            priority if (skid_vld_reg)
            begin
                if (pop)
                begin
                    skid_vld_reg <= 1'b0;
                end
            end
            else if (head_vld_reg)
            begin
                if (!pop && push)
                begin
                    skid_vld_reg <= 1'b1;
                end
                else if (pop && !push)
                begin
                    head_vld_reg <= 1'b0;
                end
            end
            else
            begin
                head_vld_reg <= push;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        priority if (skid_vld_reg)
        begin
            if (pop)
            begin
                head_reg <= skid_reg;
            end
        end
        else if (head_vld_reg)
        begin
            if (!pop && push)
            begin
                skid_reg <= push_data;
            end
            else if (pop && push)
            begin
                head_reg <= push_data;
            end
        end
        else if (push)
        begin
            head_reg <= push_data;
        end
    end

endmodule

FILE: rtl/core/tube_scan_multiplexer_crossfade_top.sv
`timescale 1ns / 1ps

// Channel  Handshake              Payload
// input    in_valid / in_stall    func, position, new_digit, old_digit, fade_level
// output   out_valid / out_stall  anode_on, anode_index, cathode_on, cathode_digit
// config   cfg_we                 cfg_index, cfg_data
//
// One transaction per clock cycle while in_stall is low: the phase update is
// one register-to-register step, and its result is buffered on accept.
// in_stall rises only when both the output head and skid registers are full.
// Reset (rst_n, async low) restores the tick registers and scan state; digit
// memory entries read as zero until written, tracked by valid bits.
// The pair for the next scanned position is prefetched, with writes forwarded.
module tube_scan_multiplexer_crossfade_top #(
    parameter int DIGITS = 6
) (
    input  logic       clk,
    input  logic       rst_n,
    // input channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] func,
    input  logic [2:0] position,
    input  logic [3:0] new_digit,
    input  logic [3:0] old_digit,
    input  logic [7:0] fade_level,
    // output channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic       anode_on,
    output logic [2:0] anode_index,
    output logic       cathode_on,
    output logic [3:0] cathode_digit,
    // configuration
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    // Configuration registers
    logic [7:0] anode_on_ticks_reg;
    logic [7:0] cathode_off_ticks_reg;
    logic [7:0] blank_ticks_reg;

    // Scan state
    logic [2:0] phase_reg,       phase_next;
    logic [2:0] pos_reg,         pos_next;
    logic [3:0] lit_reg,         lit_next;
    logic [3:0] pend_reg,        pend_next;
    logic [7:0] lit_ticks_reg,   lit_ticks_next;
    logic [7:0] second_reg,      second_next;
    logic [7:0] cnt_reg,         cnt_next;
    logic       show_old_reg,    show_old_next;
    logic [7:0] fade_reg,        fade_next;
    logic       anode_reg,       anode_next;
    logic       cathode_reg,     cathode_next;

    logic                  accept;
    logic                  tick;
    logic                  full_buf;
    logic [7:0]            full_ticks;
    logic [7:0]            cnt_dec;
    logic                  cnt_zero;
    tsmx_pkg::store_wr_t   store_wr;
    tsmx_pkg::digit_pair_t entry;
    tsmx_pkg::result_t     result;
    tsmx_pkg::result_t     out_data;

    assign in_stall = full_buf;
    assign accept   = in_valid && !full_buf;
    assign tick     = accept && (func == tsmx_pkg::FUNC_TICK);

    // A zero tick register acts as one
    assign full_ticks = (anode_on_ticks_reg == 8'd0) ? 8'd1 : anode_on_ticks_reg;
    assign cnt_dec    = cnt_reg - 8'd1;
    assign cnt_zero   = (cnt_dec == 8'd0);

    // Digit pair write: drop positions past the last digit
    assign store_wr.en   = accept && (func == tsmx_pkg::FUNC_WRITE)
                           && ({1'b0, position} < 4'(DIGITS));
    assign store_wr.addr = position;
    assign store_wr.data = '{new_digit: new_digit, old_digit: old_digit};

    // Read the entry of the position the scan will sit on next cycle
    tsmx_digit_store #(
        .DIGITS (DIGITS)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (store_wr),
        .rd_addr (pos_next),
        .rd_data (entry)
    );

    always_comb
    begin
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        lit_next       = lit_reg;
        pend_next      = pend_reg;
        lit_ticks_next = lit_ticks_reg;
        second_next    = second_reg;
        cnt_next       = cnt_reg;
        show_old_next  = show_old_reg;
        fade_next      = fade_reg;
        anode_next     = anode_reg;
        cathode_next   = cathode_reg;

        if (accept && (func == tsmx_pkg::FUNC_FADE))
        begin
            fade_next = fade_level;
        end

        if (tick)
        begin
            unique case (phase_reg)
                tsmx_pkg::PH_ENABLE:
                begin
                    anode_next = 1'b1;
                    cnt_next   = (lit_ticks_reg == 8'd0) ? 8'd1 : lit_ticks_reg;
                    phase_next = tsmx_pkg::PH_HOLD;
                end
                tsmx_pkg::PH_HOLD:
                begin
                    cnt_next = cnt_dec;
                    if (cnt_zero)
                    begin
                        anode_next = 1'b0;
                        cnt_next   = (cathode_off_ticks_reg == 8'd0)
                                     ? 8'd1 : cathode_off_ticks_reg;
                        phase_next = tsmx_pkg::PH_COFF;
                    end
                end
                tsmx_pkg::PH_COFF:
                begin
                    cnt_next = cnt_dec;
                    if (cnt_zero)
                    begin
                        // Second half of a cross-fade: switch to the new digit
                        if (show_old_reg && (second_reg != 8'd0))
                        begin
                            lit_next       = pend_reg;
                            lit_ticks_next = second_reg;
                            show_old_next  = 1'b0;
                            cathode_next   = 1'b1;
                            phase_next     = tsmx_pkg::PH_ENABLE;
                        end
                        else
                        begin
                            cathode_next = 1'b0;
                            cnt_next     = (blank_ticks_reg == 8'd0)
                                           ? 8'd1 : blank_ticks_reg;
                            phase_next   = tsmx_pkg::PH_BLANK;
                        end
                    end
                end
                tsmx_pkg::PH_BLANK:
                begin
                    cnt_next = cnt_dec;
                    if (cnt_zero)
                    begin
                        pos_next   = (pos_reg == 3'(DIGITS - 1)) ? 3'd0 : pos_reg + 3'd1;
                        phase_next = tsmx_pkg::PH_SELECT;
                    end
                end
                default:
                begin
                    // Select cathode: split the on-time while a fade is running
                    if ((fade_reg >= full_ticks) || (entry.old_digit == entry.new_digit))
                    begin
                        lit_next       = entry.new_digit;
                        lit_ticks_next = full_ticks;
                        second_next    = 8'd0;
                        show_old_next  = 1'b0;
                    end
                    else
                    begin
                        lit_next       = entry.old_digit;
                        second_next    = fade_reg;
                        lit_ticks_next = full_ticks - fade_reg;
                        show_old_next  = 1'b1;
                    end
                    pend_next    = entry.new_digit;
                    cathode_next = 1'b1;
                    phase_next   = tsmx_pkg::PH_ENABLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            anode_on_ticks_reg    <= tsmx_pkg::ANODE_ON_RST;
            cathode_off_ticks_reg <= tsmx_pkg::CATHODE_OFF_RST;
            blank_ticks_reg       <= tsmx_pkg::BLANK_RST;
            phase_reg             <= tsmx_pkg::PH_SELECT;
            pos_reg               <= 3'd0;
            lit_reg               <= 4'd0;
            pend_reg              <= 4'd0;
            lit_ticks_reg         <= tsmx_pkg::ANODE_ON_RST;
            second_reg            <= 8'd0;
            cnt_reg               <= 8'd0;
            show_old_reg          <= 1'b0;
            fade_reg              <= tsmx_pkg::ANODE_ON_RST;
            anode_reg             <= 1'b0;
            cathode_reg           <= 1'b0;
        end
        else
        begin
            // Config writes past the register list are dropped
            if (cfg_we)
            begin
                unique case (cfg_index)
                    tsmx_pkg::CFG_ANODE_ON:    anode_on_ticks_reg    <= cfg_data;
                    tsmx_pkg::CFG_CATHODE_OFF: cathode_off_ticks_reg <= cfg_data;
                    tsmx_pkg::CFG_BLANK:       blank_ticks_reg       <= cfg_data;
                    default:                   ;
                endcase
            end
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            lit_reg       <= lit_next;
            pend_reg      <= pend_next;
            lit_ticks_reg <= lit_ticks_next;
            second_reg    <= second_next;
            cnt_reg       <= cnt_next;
            show_old_reg  <= show_old_next;
            fade_reg      <= fade_next;
            anode_reg     <= anode_next;
            cathode_reg   <= cathode_next;
        end
    end

    // Every transaction reports the drive state after its update
    assign result.anode_on      = anode_next;
    assign result.anode_index   = pos_next;
    assign result.cathode_on    = cathode_next;
    assign result.cathode_digit = lit_next;

    tsmx_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (result),
        .full      (full_buf),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign anode_on      = out_data.anode_on;
    assign anode_index   = out_data.anode_index;
    assign cathode_on    = out_data.cathode_on;
    assign cathode_digit = out_data.cathode_digit;

endmodule

FILE: rtl/core/tsmx_checker.sv
`timescale 1ns / 1ps

`include "assert_macros.svh"

module tsmx_checker #(
    parameter int DIGITS = 6
) (
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic       anode_on,
    input logic [2:0] anode_index,
    input logic       cathode_on,
    input logic [3:0] cathode_digit
);

    // Input backpressure only once a result is already waiting
    `ASSERT_IMPLIES(a_stall_needs_result, !out_valid, !in_stall)

    // The anode never lights without its cathode selected
    `ASSERT_IMPLIES(a_anode_needs_cathode, out_valid && anode_on, cathode_on)

    // Scanned position stays within the display
    `ASSERT_IMPLIES(a_index_range, out_valid, {1'b0, anode_index} < 4'(DIGITS))

    // A stalled result holds
    `ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(anode_on) && $stable(anode_index)
        && $stable(cathode_on) && $stable(cathode_digit))

endmodule

bind tube_scan_multiplexer_crossfade_top tsmx_checker #(.DIGITS(DIGITS)) u_checker (.*);
